// ----- hdl/bmsv_pkg.sv -----
// bmsv_pkg: constants, access descriptor type and view helper functions
// for the banked memory with sub-word views; no dependencies
package bmsv_pkg;

    localparam int NUM_BANKS      = 8;
    localparam int WORDS_PER_BANK = 2000;
    localparam int DEPTH          = NUM_BANKS * WORDS_PER_BANK;
    localparam int ADDR_W         = $clog2(DEPTH);
    localparam int DATA_W         = 32;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [2:0] VIEW_WORD = 3'd0;
    localparam logic [2:0] VIEW_B1   = 3'd1;
    localparam logic [2:0] VIEW_B2   = 3'd2;
    localparam logic [2:0] VIEW_B4   = 3'd3;
    localparam logic [2:0] VIEW_B8   = 3'd4;
    localparam logic [2:0] VIEW_B16  = 3'd5;

    typedef struct packed {
        logic              op;
        logic [2:0]        view;
        logic              err;
        logic [ADDR_W-1:0] addr;
        logic [4:0]        shift;
    } t_acc;

    function automatic logic [DATA_W-1:0] elem_mask(input logic [2:0] view);
        logic [DATA_W-1:0] m;
        case (view)
            VIEW_B1:  m = 32'h0000_0001;
            VIEW_B2:  m = 32'h0000_0003;
            VIEW_B4:  m = 32'h0000_000f;
            VIEW_B8:  m = 32'h0000_00ff;
            VIEW_B16: m = 32'h0000_ffff;
            default:  m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

endpackage

// ----- hdl/bmsv_ram.sv -----
// bmsv_ram: generic single-write, single-read memory with registered read
// no dependencies
module bmsv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/bmsv_decode.sv -----
// bmsv_decode: range checks and word address / bit offset of one access
// depends on bmsv_pkg
module bmsv_decode (
    input  logic             i_operation,
    input  logic [2:0]       i_view,
    input  logic [2:0]       i_bank,
    input  logic [15:0]      i_location,
    output bmsv_pkg::t_acc   o_acc
);
    import bmsv_pkg::*;

    logic [15:0] word_idx;
    logic [4:0]  shift;
    logic [31:0] limit;
    logic        view_ok;
    logic        bank_ok;
    logic [31:0] addr_full;

    always_comb begin
        view_ok = 1'b1;
        unique case (i_view)
            VIEW_WORD: begin
                word_idx = i_location;
                shift    = 5'd0;
                limit    = 32'(WORDS_PER_BANK);
            end
            VIEW_B1: begin
                word_idx = {5'd0, i_location[15:5]};
                shift    = i_location[4:0];
                limit    = 32'(WORDS_PER_BANK * 32);
            end
            VIEW_B2: begin
                word_idx = {4'd0, i_location[15:4]};
                shift    = {i_location[3:0], 1'b0};
                limit    = 32'(WORDS_PER_BANK * 16);
            end
            VIEW_B4: begin
                word_idx = {3'd0, i_location[15:3]};
                shift    = {i_location[2:0], 2'b0};
                limit    = 32'(WORDS_PER_BANK * 8);
            end
            VIEW_B8: begin
                word_idx = {2'd0, i_location[15:2]};
                shift    = {i_location[1:0], 3'b0};
                limit    = 32'(WORDS_PER_BANK * 4);
            end
            VIEW_B16: begin
                word_idx = {1'd0, i_location[15:1]};
                shift    = {i_location[0], 4'b0};
                limit    = 32'(WORDS_PER_BANK * 2);
            end
            default: begin
                word_idx = i_location;
                shift    = 5'd0;
                limit    = 32'd0;
                view_ok  = 1'b0;
            end
        endcase
    end

    assign bank_ok   = 32'(i_bank) < 32'(NUM_BANKS);
    assign addr_full = 32'(i_bank) * 32'(WORDS_PER_BANK) + 32'(word_idx);

    assign o_acc.op    = i_operation;
    assign o_acc.view  = i_view;
    assign o_acc.err   = !(bank_ok && view_ok && (32'(i_location) < limit));
    assign o_acc.addr  = addr_full[ADDR_W-1:0];
    assign o_acc.shift = shift;
endmodule

// ----- hdl/banked_memory_subword_views.sv -----
// banked_memory_subword_views: top level, read-modify-write stage with
// forwarding, output register and post-reset clearing pass
// depends on bmsv_pkg, bmsv_decode, bmsv_ram
// pipeline: an accepted item is held in the modify stage, its result in the output register
// throughput: one item per cycle unless i_ready stalls the output; the single memory
// read port and the read-modify-write stage with forwarding of the previous write set this
// reset: a clearing pass over all NUM_BANKS * WORDS_PER_BANK words (16000)
// zeroes the memory, o_ready stays low until it ends
module banked_memory_subword_views (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [2:0]  i_view,
    input  logic [2:0]  i_bank,
    input  logic [15:0] i_location,
    input  logic [31:0] i_write_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_read_value,
    output logic        o_error
);
    import bmsv_pkg::*;

    t_acc              dec;
    logic              in_fire;
    logic              s1_fire;
    logic              s1_wen;
    logic [DATA_W-1:0] rdata;
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] new_word;
    logic [DATA_W-1:0] rd_result;

    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_s1_valid;
    t_acc              r_s1;
    logic [DATA_W-1:0] r_s1_wval;
    logic              r_fwd_valid;
    logic [DATA_W-1:0] r_fwd_data;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_value;
    logic              r_error;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;

    bmsv_decode u_decode (
        .i_operation (i_operation),
        .i_view      (i_view),
        .i_bank      (i_bank),
        .i_location  (i_location),
        .o_acc       (dec)
    );

    assign s1_fire = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_clr_busy && (!r_s1_valid || s1_fire);
    assign in_fire = i_valid && o_ready;
    assign s1_wen  = s1_fire && (r_s1.op == OP_WRITE) && !r_s1.err;

    // forward the word written by the previous item when it hits the same entry
    assign word      = r_fwd_valid ? r_fwd_data : rdata;
    assign mask      = elem_mask(r_s1.view);
    assign rd_result = (word >> r_s1.shift) & mask;
    assign new_word  = (word & ~(mask << r_s1.shift)) | ((r_s1_wval & mask) << r_s1.shift);

    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_wen;
            ram_waddr = r_s1.addr;
            ram_wdata = new_word;
        end
    end

    bmsv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_fire),
        .i_raddr (dec.addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_fire) begin
                r_s1_valid  <= 1'b1;
                r_fwd_valid <= s1_wen && (r_s1.addr == dec.addr);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1       <= dec;
            r_s1_wval  <= i_write_value;
            r_fwd_data <= new_word;
        end
        if (s1_fire) begin
            r_read_value <= (r_s1.err || r_s1.op == OP_WRITE) ? '0 : rd_result;
            r_error      <= r_s1.err;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_error      = r_error;

`ifndef SYNTH
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_ready)
        else $error("item accepted during clearing pass");
    a_no_rmw_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !s1_wen)
        else $error("memory update during clearing pass");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_read_value == '0))
        else $error("error result with nonzero read value");
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_fire) |=> r_s1_valid)
        else $error("stalled item dropped from modify stage");
`endif
endmodule
